// ----- design/ac_remote_manchester_ir_sender_core_assert.svh -----
// Assertion macros for the manchester ir sender core
// Each macro checks one implication, sampled on the rising clock edge
// Depends on nothing; compiled out when SYNTHESIS is defined
`ifndef AC_REMOTE_MANCHESTER_IR_SENDER_CORE_ASSERT_SVH
`define AC_REMOTE_MANCHESTER_IR_SENDER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ACRMS_ASSERT_IMP(lbl, clk_s, rst_n, pre, post) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("acrms: same-cycle check failed");

// next-cycle implication
`define ACRMS_ASSERT_NXT(lbl, clk_s, rst_n, pre, post) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("acrms: next-cycle check failed");

`else

`define ACRMS_ASSERT_IMP(lbl, clk_s, rst_n, pre, post)

`define ACRMS_ASSERT_NXT(lbl, clk_s, rst_n, pre, post)

`endif

`endif

// ----- design/acrms_pkg.sv -----
// Shared types, constants and the command word packing function
// Used by every module of the manchester ir sender core
`timescale 1ns / 1ps
`default_nettype none

package acrms_pkg;

	// packed command layout
	localparam int unsigned PACK_BITS = 34;
	localparam int unsigned WORD_MAX  = 64;

	// temperature biases and fixed low bits
	localparam logic [4:0] SET_TEMP_BIAS   = 5'd15;
	localparam logic [4:0] SENSE_TEMP_BIAS = 5'd5;
	localparam logic [1:0] LOW_BITS_CODE   = 2'd2;

	// waveform segment lengths in units
	localparam logic [2:0] HEAD_UNITS = 3'd3;
	localparam logic [2:0] TAIL_UNITS = 3'd4;

	// register map
	localparam int unsigned REG_UNIT_LEN   = 0;
	localparam logic [15:0] UNIT_LEN_RESET = 16'd1000;

	// waveform segment
	typedef enum logic [2:0] {
		SEG_IDLE,
		SEG_HEAD_MARK,
		SEG_HEAD_SPACE,
		SEG_BITS,
		SEG_TAIL
	} seg_t;

	// queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// one result
	typedef struct packed {
		logic ir_level;
		logic busy;
	} res_t;

	// pack the settings into the command word
	function automatic logic [PACK_BITS-1:0] pack_word(
		input logic       power_wanted,
		input logic       power_actual,
		input logic [2:0] ac_mode,
		input logic [1:0] fan_speed,
		input logic       notify,
		input logic       swing_horizontal,
		input logic       swing_vertical,
		input logic       ifeel_on,
		input logic [5:0] set_temperature,
		input logic [5:0] sensed_temperature,
		input logic       sleep_on
	);
		logic [4:0] temp;
		temp = notify ? (sensed_temperature[4:0] - SENSE_TEMP_BIAS)
			: (set_temperature[4:0] - SET_TEMP_BIAS);
		return {power_wanted ^ power_actual, ac_mode, fan_speed, notify,
			swing_horizontal, swing_vertical, ifeel_on, temp, sleep_on,
			16'd0, LOW_BITS_CODE};
	endfunction

endpackage

`default_nettype wire

// ----- design/ac_remote_manchester_ir_sender_core.sv -----
// Top level of the manchester ir sender: register port, front end, queue, sequencer
// Depends on acrms_pkg, acrms_front, acrms_queue, acrms_back and the assert header
//
//   port group  | direction | handshake
//   cmd_*       | in        | cmd_valid / cmd_stall, one request per accept
//   res_*       | out       | res_valid / res_stall, one result per request
//   apb         | in        | psel / penable / pwrite, pready tied high
//
// One request per clock sustained while res_stall is low; a result appears once its
// request is accepted and has passed the two-entry queue and the result register.
// The unit timer and waveform counters all update together, only when a request is popped.
// res_stall holds the result register; the queue absorbs two more requests before
// cmd_stall rises. Reset clears the sequencer to idle with the pin low.
`timescale 1ns / 1ps
`default_nettype none

`include "ac_remote_manchester_ir_sender_core_assert.svh"

module ac_remote_manchester_ir_sender_core #(
	parameter int unsigned CODE_BITS     = 34,
	parameter int unsigned FRAME_REPEATS = 3
) (
	input  wire         clk,
	input  wire         arst_n,
	// configuration port
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// request channel
	input  wire         cmd_valid,
	output logic        cmd_stall,
	input  wire         action,
	input  wire         power_wanted,
	input  wire         power_actual,
	input  wire  [2:0]  ac_mode,
	input  wire  [1:0]  fan_speed,
	input  wire         notify,
	input  wire         swing_horizontal,
	input  wire         swing_vertical,
	input  wire         ifeel_on,
	input  wire  [5:0]  set_temperature,
	input  wire  [5:0]  sensed_temperature,
	input  wire         sleep_on,
	// result channel
	output logic        res_valid,
	input  wire         res_stall,
	output logic        ir_level,
	output logic        busy_res
);
	import acrms_pkg::*;

	logic                 unit_hit;
	logic [15:0]          unit_len_q;
	q_stat_t              q_stat;
	logic                 push;
	logic                 pop;
	logic                 item_send;
	logic [CODE_BITS-1:0] item_word;
	logic [CODE_BITS:0]   q_rd_data;
	res_t                 res;

	// register decode, address bits below the word are byte lanes
	assign unit_hit = (paddr[2] == REG_UNIT_LEN[0]);
	assign pready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_len_q <= UNIT_LEN_RESET;
		end else if (psel && penable && pwrite && pready && unit_hit) begin
			unit_len_q <= pwdata[15:0];
		end
	end

	assign prdata = unit_hit ? {16'd0, unit_len_q} : 32'd0;

	// front end
	acrms_front #(
		.CODE_BITS(CODE_BITS)
	) u_front (
		.cmd_valid         (cmd_valid),
		.cmd_stall         (cmd_stall),
		.action            (action),
		.power_wanted      (power_wanted),
		.power_actual      (power_actual),
		.ac_mode           (ac_mode),
		.fan_speed         (fan_speed),
		.notify            (notify),
		.swing_horizontal  (swing_horizontal),
		.swing_vertical    (swing_vertical),
		.ifeel_on          (ifeel_on),
		.set_temperature   (set_temperature),
		.sensed_temperature(sensed_temperature),
		.sleep_on          (sleep_on),
		.q_stat            (q_stat),
		.push              (push),
		.item_send         (item_send),
		.item_word         (item_word)
	);

	// request queue
	acrms_queue #(
		.WIDTH(CODE_BITS + 1)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_data({item_send, item_word}),
		.pop    (pop),
		.rd_data(q_rd_data),
		.q_stat (q_stat)
	);

	// waveform sequencer
	acrms_back #(
		.CODE_BITS    (CODE_BITS),
		.FRAME_REPEATS(FRAME_REPEATS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.item_send(q_rd_data[CODE_BITS]),
		.item_word(q_rd_data[CODE_BITS-1:0]),
		.unit_len (unit_len_q),
		.pop      (pop),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

	assign ir_level = res.ir_level;
	assign busy_res = res.busy;

	// pin is low whenever no transmission is running
	`ACRMS_ASSERT_IMP(a_idle_pin_low, clk, arst_n, res_valid && !busy_res, !ir_level)
	// a held result is never overwritten
	`ACRMS_ASSERT_IMP(a_no_pop_on_held, clk, arst_n, pop, !(res_valid && res_stall))
	// every drained request shows up as a result
	`ACRMS_ASSERT_NXT(a_pop_gives_result, clk, arst_n, pop, res_valid)

endmodule

`default_nettype wire

// ----- design/acrms_front.sv -----
// Front end: takes requests, tells ticks from sends and packs the command word
// Depends on acrms_pkg; feeds acrms_queue
`timescale 1ns / 1ps
`default_nettype none

module acrms_front #(
	parameter int unsigned CODE_BITS = 34
) (
	input  wire                  cmd_valid,
	output logic                 cmd_stall,
	input  wire                  action,
	input  wire                  power_wanted,
	input  wire                  power_actual,
	input  wire [2:0]            ac_mode,
	input  wire [1:0]            fan_speed,
	input  wire                  notify,
	input  wire                  swing_horizontal,
	input  wire                  swing_vertical,
	input  wire                  ifeel_on,
	input  wire [5:0]            set_temperature,
	input  wire [5:0]            sensed_temperature,
	input  wire                  sleep_on,
	input  acrms_pkg::q_stat_t   q_stat,
	output logic                 push,
	output logic                 item_send,
	output logic [CODE_BITS-1:0] item_word
);
	import acrms_pkg::*;

	logic [PACK_BITS-1:0] packed_word;
	logic [WORD_MAX-1:0]  wide_word;

	// back pressure comes straight from the queue
	assign cmd_stall = q_stat.full;
	assign push      = cmd_valid && !q_stat.full;

	// classify and pack
	assign item_send   = action;
	assign packed_word = pack_word(power_wanted, power_actual, ac_mode, fan_speed, notify,
		swing_horizontal, swing_vertical, ifeel_on, set_temperature,
		sensed_temperature, sleep_on);
	assign wide_word = {{(WORD_MAX - PACK_BITS){1'b0}}, packed_word};
	assign item_word = wide_word[CODE_BITS-1:0];

endmodule

`default_nettype wire

// ----- design/acrms_queue.sv -----
// Two-entry queue between the front end and the waveform sequencer
// Depends on acrms_pkg for the status struct
`timescale 1ns / 1ps
`default_nettype none

module acrms_queue #(
	parameter int unsigned WIDTH = 35
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               push,
	input  wire  [WIDTH-1:0]  wr_data,
	input  wire               pop,
	output logic [WIDTH-1:0]  rd_data,
	output acrms_pkg::q_stat_t q_stat
);
	import acrms_pkg::*;

	logic [WIDTH-1:0] entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	assign rd_data      = entry_q[rd_ptr_q];
	assign q_stat.full  = count_q[1];
	assign q_stat.empty = (count_q == 2'd0);

endmodule

`default_nettype wire

// ----- design/acrms_back.sv -----
// Back end: waveform sequencer with unit timer and the result register
// Depends on acrms_pkg; drains acrms_queue
`timescale 1ns / 1ps
`default_nettype none

module acrms_back #(
	parameter int unsigned CODE_BITS     = 34,
	parameter int unsigned FRAME_REPEATS = 3
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  acrms_pkg::q_stat_t   q_stat,
	input  wire                  item_send,
	input  wire [CODE_BITS-1:0]  item_word,
	input  wire [15:0]           unit_len,
	output logic                 pop,
	output logic                 res_valid,
	input  wire                  res_stall,
	output acrms_pkg::res_t      res
);
	import acrms_pkg::*;

	localparam int unsigned BIT_W = $clog2(CODE_BITS);
	localparam int unsigned FC_W  = $clog2(FRAME_REPEATS + 1);
	localparam logic [BIT_W-1:0] BIT_TOP    = BIT_W'(CODE_BITS - 1);
	localparam logic [FC_W:0]    FRAME_LAST = (FC_W + 1)'(FRAME_REPEATS);

	seg_t                 seg_q, seg_d;
	logic [2:0]           units_q, units_d, units_m1;
	logic [15:0]          tick_q, tick_d;
	logic [BIT_W-1:0]     bit_q, bit_d, bit_m1;
	logic                 half_q, half_d;
	logic [FC_W-1:0]      frame_q, frame_d;
	logic [FC_W:0]        frame_inc;
	logic                 pin_q, pin_d;
	logic [CODE_BITS-1:0] word_q, word_d;
	logic [16:0]          tick_inc;
	logic [15:0]          len_eff;
	logic                 unit_done;
	logic                 last_frame;
	logic                 res_valid_q;
	res_t                 res_q;

	// take the next request when the result register is free or draining
	assign pop = !q_stat.empty && (!res_valid_q || !res_stall);

	// unit timer, a zero length acts as one tick
	assign len_eff    = (unit_len == 16'd0) ? 16'd1 : unit_len;
	assign tick_inc   = {1'b0, tick_q} + 17'd1;
	assign unit_done  = (tick_inc >= {1'b0, len_eff});
	assign units_m1   = units_q - 3'd1;
	assign bit_m1     = bit_q - 1'b1;
	assign frame_inc  = {1'b0, frame_q} + 1'b1;
	assign last_frame = (frame_inc >= FRAME_LAST);

	// segment next state
	always_comb begin
		seg_d = seg_q;
		if (pop) begin
			if (item_send) begin
				if (seg_q == SEG_IDLE) begin
					seg_d = SEG_HEAD_MARK;
				end
			end else if (seg_q != SEG_IDLE && unit_done) begin
				unique case (seg_q)
					SEG_HEAD_MARK: begin
						if (units_m1 == 3'd0) seg_d = SEG_HEAD_SPACE;
					end
					SEG_HEAD_SPACE: begin
						if (units_m1 == 3'd0) seg_d = SEG_BITS;
					end
					SEG_BITS: begin
						if (half_q && bit_q == '0) begin
							seg_d = last_frame ? SEG_TAIL : SEG_HEAD_MARK;
						end
					end
					SEG_TAIL: begin
						if (units_m1 == 3'd0) seg_d = SEG_IDLE;
					end
					default: seg_d = SEG_IDLE;
				endcase
			end
		end
	end

	// counters, pin and command word
	always_comb begin
		units_d = units_q;
		tick_d  = tick_q;
		bit_d   = bit_q;
		half_d  = half_q;
		frame_d = frame_q;
		pin_d   = pin_q;
		word_d  = word_q;
		if (pop) begin
			if (item_send) begin
				if (seg_q == SEG_IDLE) begin
					word_d  = item_word;
					units_d = HEAD_UNITS;
					frame_d = '0;
					bit_d   = '0;
					half_d  = 1'b0;
					tick_d  = 16'd0;
					pin_d   = 1'b1;
				end
			end else if (seg_q != SEG_IDLE) begin
				if (unit_done) begin
					tick_d = 16'd0;
					unique case (seg_q)
						SEG_HEAD_MARK: begin
							units_d = units_m1;
							if (units_m1 == 3'd0) begin
								units_d = HEAD_UNITS;
								pin_d   = 1'b0;
							end
						end
						SEG_HEAD_SPACE: begin
							units_d = units_m1;
							if (units_m1 == 3'd0) begin
								bit_d  = BIT_TOP;
								half_d = 1'b0;
								pin_d  = ~word_q[BIT_TOP];
							end
						end
						SEG_BITS: begin
							if (!half_q) begin
								half_d = 1'b1;
								pin_d  = word_q[bit_q];
							end else if (bit_q == '0) begin
								frame_d = frame_inc[FC_W-1:0];
								pin_d   = 1'b1;
								units_d = last_frame ? TAIL_UNITS : HEAD_UNITS;
							end else begin
								bit_d  = bit_m1;
								half_d = 1'b0;
								pin_d  = ~word_q[bit_m1];
							end
						end
						SEG_TAIL: begin
							units_d = units_m1;
							if (units_m1 == 3'd0) pin_d = 1'b0;
						end
						default: pin_d = 1'b0;
					endcase
				end else begin
					tick_d = tick_inc[15:0];
				end
			end
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q   <= SEG_IDLE;
			units_q <= 3'd0;
			tick_q  <= 16'd0;
			bit_q   <= '0;
			half_q  <= 1'b0;
			frame_q <= '0;
			pin_q   <= 1'b0;
		end else begin
			seg_q   <= seg_d;
			units_q <= units_d;
			tick_q  <= tick_d;
			bit_q   <= bit_d;
			half_q  <= half_d;
			frame_q <= frame_d;
			pin_q   <= pin_d;
		end
	end

	// command word holds until the next send that is popped while the sequencer is idle
	always_ff @(posedge clk) begin
		word_q <= word_d;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (pop) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q.ir_level <= pin_d;
			res_q.busy     <= (seg_d != SEG_IDLE);
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire
